// ===== rtl/qrad_pkg.sv =====
// ----------------------------------------------------------------------------
// QR alphanumeric encoder package
// Shared types, constants and the character lookup of the encoder.
// ----------------------------------------------------------------------------
package qrad_pkg;

    localparam int MAX_CODEWORDS_DEF = 64;
    localparam int CAP_W             = 7;
    localparam int CAP_RESET         = 16;
    localparam int SYMBOL_COUNT      = 45;
    localparam int PAIR_BITS         = 11;
    localparam int SINGLE_BITS       = 6;
    localparam int TERM_BITS         = 4;
    localparam int BUF_W             = 18;
    localparam int BB_W              = 5;
    localparam int IDX_W             = 6;

    localparam logic [7:0] PAD_FIRST  = 8'd236;
    localparam logic [7:0] PAD_SECOND = 8'd17;

    localparam logic OP_CHAR   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        EMIT_DRAIN,
        EMIT_PAD,
        EMIT_INVALID,
        EMIT_OVERFLOW,
        EMIT_MARKER
    } emit_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INVALID,
        S_DRAIN,
        S_FIN_DRAIN,
        S_FIN_TERM,
        S_FIN_TAIL,
        S_FLUSH,
        S_PAD,
        S_CLEAR
    } ctrl_state_t;

    typedef struct packed {
        logic       start;
        logic       hold;
        logic       pair;
        logic       single;
        logic       align;
        logic       clear;
        logic       emit;
        emit_kind_t kind;
        logic       last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic char_ok;
        logic holding;
        logic bb_ge8;
        logic bb_is8;
        logic bb_zero;
        logic has_room;
        logic sent_last;
        logic can_emit;
        logic emitted;
    } dp_status_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } sym_t;

    // Index of an ASCII code in the 45-symbol alphanumeric set.
    function automatic sym_t sym_lookup(input logic [7:0] ch);
        sym_t r;
        r.ok  = 1'b1;
        r.idx = '0;
        case (ch) inside
            [8'h30:8'h39]: r.idx = IDX_W'(ch - 8'h30);
            [8'h41:8'h5A]: r.idx = IDX_W'(ch - 8'h37);
            8'h20:         r.idx = 6'd36;
            8'h24:         r.idx = 6'd37;
            8'h25:         r.idx = 6'd38;
            8'h2A:         r.idx = 6'd39;
            8'h2B:         r.idx = 6'd40;
            8'h2D:         r.idx = 6'd41;
            8'h2E:         r.idx = 6'd42;
            8'h2F:         r.idx = 6'd43;
            8'h3A:         r.idx = 6'd44;
            default:       r.ok  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/qr_alphanumeric_data_encoder_top.sv =====
// ----------------------------------------------------------------------------
// QR alphanumeric data encoder
// Packs alphanumeric characters into 8-bit data codewords and pads a message.
// ----------------------------------------------------------------------------
//  Port group   Direction  Handshake              Beat contents
//  input        in         in_valid / in_ready    operation, character
//  output       out        out_valid / out_ready  codeword, last, status
//  config       in         cfg_wr_en              cfg_wr_data (capacity)
//
//  A first character is held and the encoder stays ready. A second character
//  is paired and its whole bytes are drained before it returns to idle; an
//  invalid character gives one result with invalid status. A finish with room
//  left drains the buffer, adds terminator and alignment and pads up to the
//  capacity; with no room left it drains the buffered bytes and marks its
//  last result as last. The single output register sends one codeword per cycle
//  unless out_ready stalls it; a finish ends with a step that clears the message.
//  A stalled output holds the controller in its current step; the next input
//  beat is taken while the last result still waits in the output register.
//  Reset clears the message state and sets the capacity to 16 codewords.
// ----------------------------------------------------------------------------
module qr_alphanumeric_data_encoder_top #(
    parameter int MAX_CODEWORDS = qrad_pkg::MAX_CODEWORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [qrad_pkg::CAP_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic [7:0]                  character,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  codeword,
    output logic                        last,
    output logic [1:0]                  status
);

    qrad_pkg::ctrl_cmd_t  cmd;
    qrad_pkg::dp_status_t st;

    qrad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .st        (st),
        .cmd       (cmd)
    );

    qrad_datapath #(
        .MAX_CODEWORDS (MAX_CODEWORDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .character   (character),
        .cmd         (cmd),
        .st          (st),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .codeword    (codeword),
        .last        (last),
        .status      (status)
    );

    // At most one datapath update per cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.hold, cmd.pair, cmd.align, cmd.emit, cmd.clear}))
        else $error("more than one datapath command in a cycle");

    // A result is only produced when the output register can take it.
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.can_emit)
        else $error("result emitted into a full output register");

    // A byte is only drained when a whole byte is buffered.
    a_drain_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.kind == qrad_pkg::EMIT_DRAIN) |-> st.bb_ge8)
        else $error("drain with fewer than eight buffered bits");

    // Terminator and alignment are added only while capacity remains.
    a_align_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.align |-> st.has_room)
        else $error("terminator added beyond capacity");

endmodule

// ===== rtl/qrad_ctrl.sv =====
// ----------------------------------------------------------------------------
// QR alphanumeric encoder controller
// Sequences character intake, byte draining, terminator and pad generation.
// ----------------------------------------------------------------------------
module qrad_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  operation,
    output logic                  in_ready,
    input  qrad_pkg::dp_status_t  st,
    output qrad_pkg::ctrl_cmd_t   cmd
);

    qrad_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qrad_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = qrad_pkg::EMIT_DRAIN;
        state_next = state_reg;
        in_ready   = (state_reg == qrad_pkg::S_IDLE);
        case (state_reg)
            qrad_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (operation == qrad_pkg::OP_FINISH)
                    begin
                        cmd.single = 1'b1;
                        state_next = qrad_pkg::S_FIN_DRAIN;
                    end
                    else if (!st.char_ok)
                    begin
                        state_next = qrad_pkg::S_INVALID;
                    end
                    else if (!st.holding)
                    begin
                        cmd.hold = 1'b1;
                    end
                    else
                    begin
                        cmd.pair   = 1'b1;
                        state_next = qrad_pkg::S_DRAIN;
                    end
                end
            end
            qrad_pkg::S_INVALID:
            begin
                if (st.can_emit)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = qrad_pkg::EMIT_INVALID;
                    state_next = qrad_pkg::S_IDLE;
                end
            end
            qrad_pkg::S_DRAIN:
            begin
                if (!st.bb_ge8)
                begin
                    state_next = qrad_pkg::S_IDLE;
                end
                else if (st.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = qrad_pkg::EMIT_DRAIN;
                end
            end
            qrad_pkg::S_FIN_DRAIN:
            begin
                // The byte is final when it reaches capacity and empties the buffer.
                if (!st.bb_ge8)
                begin
                    state_next = qrad_pkg::S_FIN_TERM;
                end
                else if (st.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = qrad_pkg::EMIT_DRAIN;
                    cmd.last = st.bb_is8 && st.sent_last;
                end
            end
            qrad_pkg::S_FIN_TERM:
            begin
                if (st.has_room)
                begin
                    cmd.align  = 1'b1;
                    state_next = qrad_pkg::S_FLUSH;
                end
                else
                begin
                    state_next = qrad_pkg::S_FIN_TAIL;
                end
            end
            qrad_pkg::S_FIN_TAIL:
            begin
                if (!st.bb_zero || !st.emitted)
                begin
                    if (st.can_emit)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = st.bb_zero ? qrad_pkg::EMIT_MARKER
                                                : qrad_pkg::EMIT_OVERFLOW;
                        cmd.last   = 1'b1;
                        state_next = qrad_pkg::S_CLEAR;
                    end
                end
                else
                begin
                    state_next = qrad_pkg::S_CLEAR;
                end
            end
            qrad_pkg::S_FLUSH:
            begin
                if (!st.bb_ge8)
                begin
                    state_next = qrad_pkg::S_PAD;
                end
                else if (st.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = qrad_pkg::EMIT_DRAIN;
                    cmd.last = st.bb_is8 && st.sent_last;
                end
            end
            qrad_pkg::S_PAD:
            begin
                if (!st.has_room)
                begin
                    state_next = qrad_pkg::S_CLEAR;
                end
                else if (st.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = qrad_pkg::EMIT_PAD;
                    cmd.last = st.sent_last;
                end
            end
            qrad_pkg::S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = qrad_pkg::S_IDLE;
            end
            default:
            begin
                state_next = qrad_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/qrad_datapath.sv =====
// ----------------------------------------------------------------------------
// QR alphanumeric encoder datapath
// Character pairing, bit buffer, codeword counter, pad toggle, output register.
// ----------------------------------------------------------------------------
module qrad_datapath #(
    parameter int MAX_CODEWORDS = qrad_pkg::MAX_CODEWORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [qrad_pkg::CAP_W-1:0]  cfg_wr_data,
    input  logic [7:0]                  character,
    input  qrad_pkg::ctrl_cmd_t         cmd,
    output qrad_pkg::dp_status_t        st,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [7:0]                  codeword,
    output logic                        last,
    output logic [1:0]                  status
);

    localparam int SENT_W = $clog2(MAX_CODEWORDS + 1);
    localparam int CAP_W  = qrad_pkg::CAP_W;
    localparam int BUF_W  = qrad_pkg::BUF_W;
    localparam int BB_W   = qrad_pkg::BB_W;
    localparam int IDX_W  = qrad_pkg::IDX_W;
    localparam int PAIR_W = qrad_pkg::PAIR_BITS;

    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [IDX_W-1:0]   held_reg, held_next;
    logic               holding_reg, holding_next;
    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic [BB_W-1:0]    bb_reg, bb_next;
    logic [SENT_W-1:0]  sent_reg, sent_next;
    logic               pad_sel_reg, pad_sel_next;
    logic               emitted_reg, emitted_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         codeword_reg, codeword_next;
    logic               last_reg, last_next;
    qrad_pkg::status_t  status_reg, status_next;

    qrad_pkg::sym_t     sym;
    logic [CAP_W-1:0]   cap_eff;
    logic [CAP_W-1:0]   sent_ext;
    logic [PAIR_W-1:0]  pair_value;
    logic [BB_W-1:0]    term_bits;
    logic [BB_W-1:0]    fill_end;
    logic [BB_W-1:0]    align_shift;
    logic [BB_W-1:0]    bb_less8;
    logic [7:0]         drain_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(qrad_pkg::CAP_RESET);
            held_reg      <= '0;
            holding_reg   <= 1'b0;
            buf_reg       <= '0;
            bb_reg        <= '0;
            sent_reg      <= '0;
            pad_sel_reg   <= 1'b0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            held_reg      <= held_next;
            holding_reg   <= holding_next;
            buf_reg       <= buf_next;
            bb_reg        <= bb_next;
            sent_reg      <= sent_next;
            pad_sel_reg   <= pad_sel_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        codeword_reg <= codeword_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
    end

    assign sym      = qrad_pkg::sym_lookup(character);
    assign sent_ext = CAP_W'(sent_reg);

    // Capacity values outside 1..MAX_CODEWORDS are clamped.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CAP_W'(1);
        end
        else if (cap_reg > CAP_W'(MAX_CODEWORDS))
        begin
            cap_eff = CAP_W'(MAX_CODEWORDS);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign pair_value = PAIR_W'(held_reg) * PAIR_W'(qrad_pkg::SYMBOL_COUNT)
                        + PAIR_W'(sym.idx);
    assign bb_less8   = bb_reg - BB_W'(8);
    assign drain_byte = 8'(buf_reg >> bb_less8);

    // Terminator is four zero bits, fewer if they overrun the last codeword.
    always_comb
    begin
        if (st.has_room && st.sent_last && (bb_reg > BB_W'(qrad_pkg::TERM_BITS)))
        begin
            term_bits = BB_W'(8) - bb_reg;
        end
        else
        begin
            term_bits = BB_W'(qrad_pkg::TERM_BITS);
        end
        fill_end    = (bb_reg + term_bits + BB_W'(7)) & ~BB_W'(7);
        align_shift = fill_end - bb_reg;
    end

    always_comb
    begin
        st.char_ok   = sym.ok;
        st.holding   = holding_reg;
        st.bb_ge8    = (bb_reg >= BB_W'(8));
        st.bb_is8    = (bb_reg == BB_W'(8));
        st.bb_zero   = (bb_reg == '0);
        st.has_room  = (sent_ext < cap_eff);
        st.sent_last = ({1'b0, sent_ext} + (CAP_W + 1)'(1)) >= {1'b0, cap_eff};
        st.can_emit  = !out_valid_reg || out_ready;
        st.emitted   = emitted_reg;
    end

    always_comb
    begin
        cap_next       = cfg_wr_en ? cfg_wr_data : cap_reg;
        held_next      = held_reg;
        holding_next   = holding_reg;
        buf_next       = buf_reg;
        bb_next        = bb_reg;
        sent_next      = sent_reg;
        pad_sel_next   = pad_sel_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg && !out_ready;
        codeword_next  = codeword_reg;
        last_next      = last_reg;
        status_next    = status_reg;

        if (cmd.start)
        begin
            emitted_next = 1'b0;
        end

        if (cmd.hold)
        begin
            held_next    = sym.idx;
            holding_next = 1'b1;
        end

        if (cmd.pair)
        begin
            buf_next     = {buf_reg[BUF_W-PAIR_W-1:0], pair_value};
            bb_next      = bb_reg + BB_W'(PAIR_W);
            held_next    = '0;
            holding_next = 1'b0;
        end

        if (cmd.single && holding_reg)
        begin
            buf_next     = {buf_reg[BUF_W-IDX_W-1:0], held_reg};
            bb_next      = bb_reg + BB_W'(qrad_pkg::SINGLE_BITS);
            held_next    = '0;
            holding_next = 1'b0;
        end

        if (cmd.align)
        begin
            buf_next = buf_reg << align_shift;
            bb_next  = fill_end;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            emitted_next   = 1'b1;
            last_next      = cmd.last;
            codeword_next  = '0;
            status_next    = qrad_pkg::ST_OK;
            case (cmd.kind)
                qrad_pkg::EMIT_DRAIN:
                begin
                    bb_next  = bb_less8;
                    buf_next = buf_reg & ((BUF_W'(1) << bb_less8) - BUF_W'(1));
                    if (st.has_room)
                    begin
                        codeword_next = drain_byte;
                        sent_next     = sent_reg + SENT_W'(1);
                    end
                    else
                    begin
                        status_next = qrad_pkg::ST_OVERFLOW;
                    end
                end
                qrad_pkg::EMIT_PAD:
                begin
                    codeword_next = pad_sel_reg ? qrad_pkg::PAD_SECOND
                                                : qrad_pkg::PAD_FIRST;
                    sent_next     = sent_reg + SENT_W'(1);
                    pad_sel_next  = !pad_sel_reg;
                end
                qrad_pkg::EMIT_INVALID:
                begin
                    status_next = qrad_pkg::ST_INVALID;
                end
                qrad_pkg::EMIT_OVERFLOW:
                begin
                    status_next = qrad_pkg::ST_OVERFLOW;
                end
                default:
                begin
                    status_next = qrad_pkg::ST_OK;
                end
            endcase
        end

        if (cmd.clear)
        begin
            held_next    = '0;
            holding_next = 1'b0;
            buf_next     = '0;
            bb_next      = '0;
            sent_next    = '0;
            pad_sel_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign codeword  = codeword_reg;
    assign last      = last_reg;
    assign status    = status_reg;

endmodule
